[rtl/ilt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and codes of the IRC line tokenizer
// Character codes, token classes, status codes, parser phases and the item
// and result records passed between the front end and the parser.
// ----------------------------------------------------------------------------
package ilt_pkg;

  // Characters with a meaning in the line grammar
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_N   = 8'h6E;

  localparam logic [3:0] MAX_PARAMS = 4'd15;
  localparam logic [1:0] NUM_DIGITS = 2'd3;

  // Token classes
  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_TAG_KEY = 4'd1;
  localparam logic [3:0] CLS_TAG_VAL = 4'd2;
  localparam logic [3:0] CLS_PREFIX  = 4'd3;
  localparam logic [3:0] CLS_CMD_LTR = 4'd4;
  localparam logic [3:0] CLS_CMD_DIG = 4'd5;
  localparam logic [3:0] CLS_MIDDLE  = 4'd6;
  localparam logic [3:0] CLS_TRAIL   = 4'd7;
  localparam logic [3:0] CLS_DELIM   = 4'd8;

  // Line status
  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_BAD_PFX   = 3'd3;
  localparam logic [2:0] ST_BAD_CMD   = 3'd4;
  localparam logic [2:0] ST_BAD_PARAM = 3'd5;
  localparam logic [2:0] ST_NO_TERM   = 3'd6;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_KEY_FIRST   = 4'd1,
    PH_KEY         = 4'd2,
    PH_VAL_FIRST   = 4'd3,
    PH_VAL         = 4'd4,
    PH_AFTER_TAGS  = 4'd5,
    PH_PFX_FIRST   = 4'd6,
    PH_PFX         = 4'd7,
    PH_CMD_FIRST   = 4'd8,
    PH_CMD_ALPHA   = 4'd9,
    PH_CMD_NUM     = 4'd10,
    PH_PSPACE      = 4'd11,
    PH_MIDDLE      = 4'd12,
    PH_TRAIL_FIRST = 4'd13,
    PH_TRAIL       = 4'd14,
    PH_DONE        = 4'd15
  } phase_t;

  // One byte after the front end has classified it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_alpha;
    logic       is_digit;
    logic       is_brk;
    logic       is_key_char;
  } byte_info_t;

  // Handshake between the front-end queue and the parser
  typedef struct packed {
    logic       valid;
    byte_info_t item;
  } front_out_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [3:0] token_class;
    logic       token_start;
    logic [3:0] param_index;
    logic       command_is_numeric;
    logic [9:0] command_number;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

[rtl/ilt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_front: byte classifier and input queue
// Tags each incoming byte with its character kind and holds it in a
// two-entry queue until the parser takes it.
// ----------------------------------------------------------------------------
module ilt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output ilt_pkg::front_out_t fout,
  input  logic                take
);

  ilt_pkg::byte_info_t info;
  ilt_pkg::byte_info_t q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_push;

  // Classify
  always_comb begin
    info.data        = in_byte;
    info.last        = in_last;
    info.is_alpha    = ((in_byte >= ilt_pkg::CH_UP_A) && (in_byte <= ilt_pkg::CH_UP_Z)) ||
                       ((in_byte >= ilt_pkg::CH_LO_A) && (in_byte <= ilt_pkg::CH_LO_Z));
    info.is_digit    = (in_byte >= ilt_pkg::CH_ZERO) && (in_byte <= ilt_pkg::CH_NINE);
    info.is_brk      = (in_byte == ilt_pkg::CH_CR) || (in_byte == ilt_pkg::CH_LF);
    info.is_key_char = info.is_alpha || info.is_digit || (in_byte == ilt_pkg::CH_DASH);
  end

  assign full    = (count == 2'd2);
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign fout.valid = (count != 2'd0);
  assign fout.item  = q[rd_ptr];

endmodule

[rtl/ilt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_back: line parser and result queue
// Walks the IRC line grammar one classified byte per cycle while the result
// queue has room; latches the first error; queues one result record per byte.
// ----------------------------------------------------------------------------
module ilt_back (
  input  logic                clk,
  input  logic                rst,
  input  ilt_pkg::front_out_t fin_q,
  output logic                take,
  output logic                empty,
  input  logic                pop,
  output ilt_pkg::result_t    res
);

  ilt_pkg::phase_t     phase, ph_u;
  logic                vendor_seen, vs_u;
  logic                vendor_required, vr_u;
  logic                escape_pending, esc_u;
  logic [3:0]          param_count, pc_u;
  logic [1:0]          digit_count, dc_u;
  logic [9:0]          number_accum, na_u;
  logic [2:0]          error_latch, err_u;

  ilt_pkg::phase_t     phase_next;
  logic                vendor_seen_next, vendor_required_next, escape_pending_next;
  logic [3:0]          param_count_next;
  logic [1:0]          digit_count_next;
  logic [9:0]          number_accum_next;
  logic [2:0]          error_latch_next;

  ilt_pkg::byte_info_t bi;
  logic [7:0]          b;
  logic [3:0]          e_cls;
  logic [7:0]          e_char;
  logic                e_start;
  logic [2:0]          fin;
  logic                done;
  logic                esc_ok;
  logic [7:0]          esc_char;
  logic                key_bad_vendor;
  logic [9:0]          na_times10;
  ilt_pkg::result_t    r;

  ilt_pkg::result_t    oq [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  function automatic logic [2:0] end_code(ilt_pkg::phase_t ph, logic [1:0] dc,
                                          logic [3:0] pc);
    logic [2:0] c;
    begin
      unique case (ph) inside
        ilt_pkg::PH_KEY_FIRST, ilt_pkg::PH_KEY,
        ilt_pkg::PH_VAL_FIRST, ilt_pkg::PH_VAL:    c = ilt_pkg::ST_BAD_TAG;
        ilt_pkg::PH_PFX_FIRST, ilt_pkg::PH_PFX:    c = ilt_pkg::ST_BAD_PFX;
        ilt_pkg::PH_START, ilt_pkg::PH_AFTER_TAGS,
        ilt_pkg::PH_CMD_FIRST:                     c = ilt_pkg::ST_BAD_CMD;
        ilt_pkg::PH_CMD_NUM:
          c = (dc < ilt_pkg::NUM_DIGITS) ? ilt_pkg::ST_BAD_CMD : ilt_pkg::ST_NO_TERM;
        ilt_pkg::PH_PSPACE:
          c = (pc < ilt_pkg::MAX_PARAMS) ? ilt_pkg::ST_BAD_PARAM : ilt_pkg::ST_NO_TERM;
        default:                                   c = ilt_pkg::ST_NO_TERM;
      endcase
      return c;
    end
  endfunction

  assign bi   = fin_q.item;
  assign b    = bi.data;
  assign take = fin_q.valid && (count != 2'd2);

  // Escape decoding of a tag value byte
  always_comb begin
    esc_ok   = 1'b1;
    esc_char = b;
    unique case (b)
      ilt_pkg::CH_COLON:  esc_char = ilt_pkg::CH_SEMI;
      ilt_pkg::CH_LO_S:   esc_char = ilt_pkg::CH_SPACE;
      ilt_pkg::CH_BSLASH: esc_char = ilt_pkg::CH_BSLASH;
      ilt_pkg::CH_LO_R:   esc_char = ilt_pkg::CH_CR;
      ilt_pkg::CH_LO_N:   esc_char = ilt_pkg::CH_LF;
      default:            esc_ok   = 1'b0;
    endcase
  end

  assign key_bad_vendor = vendor_required && !vendor_seen;
  assign na_times10     = {number_accum[6:0], 3'b000} + {number_accum[8:0], 1'b0};

  // Outputs of the parser: class, character, start flag and finish code
  always_comb begin
    e_cls   = ilt_pkg::CLS_NONE;
    e_char  = 8'h00;
    e_start = 1'b0;
    fin     = ilt_pkg::ST_PENDING;
    unique case (phase) inside
      ilt_pkg::PH_START, ilt_pkg::PH_AFTER_TAGS, ilt_pkg::PH_CMD_FIRST: begin
        if ((phase == ilt_pkg::PH_START && b == ilt_pkg::CH_AT) ||
            (phase != ilt_pkg::PH_CMD_FIRST && b == ilt_pkg::CH_COLON)) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b;
        end else if (bi.is_alpha) begin
          e_cls = ilt_pkg::CLS_CMD_LTR; e_char = b; e_start = 1'b1;
        end else if (bi.is_digit) begin
          e_cls = ilt_pkg::CLS_CMD_DIG; e_char = b; e_start = 1'b1;
        end else begin
          fin = ilt_pkg::ST_BAD_CMD;
        end
      end
      ilt_pkg::PH_KEY_FIRST, ilt_pkg::PH_KEY: begin
        if (bi.is_key_char ||
            ((b == ilt_pkg::CH_DOT || b == ilt_pkg::CH_COLON || b == ilt_pkg::CH_SLASH) &&
             !vendor_seen)) begin
          e_cls = ilt_pkg::CLS_TAG_KEY; e_char = b;
          e_start = (phase == ilt_pkg::PH_KEY_FIRST);
        end else if (b == ilt_pkg::CH_SLASH) begin
          fin = ilt_pkg::ST_BAD_TAG;
        end else if (key_bad_vendor) begin
          fin = ilt_pkg::ST_BAD_TAG;
        end else if (b == ilt_pkg::CH_EQ || b == ilt_pkg::CH_SEMI ||
                     b == ilt_pkg::CH_SPACE) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b;
        end else begin
          fin = ilt_pkg::ST_BAD_TAG;
        end
      end
      ilt_pkg::PH_VAL_FIRST, ilt_pkg::PH_VAL: begin
        if (escape_pending) begin
          if (esc_ok) begin
            e_cls = ilt_pkg::CLS_TAG_VAL; e_char = esc_char;
            e_start = (phase == ilt_pkg::PH_VAL_FIRST);
          end else begin
            fin = ilt_pkg::ST_BAD_TAG;
          end
        end else if (b == ilt_pkg::CH_BSLASH) begin
          e_cls = ilt_pkg::CLS_NONE;
        end else if (b == ilt_pkg::CH_SEMI || b == ilt_pkg::CH_SPACE) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b;
        end else if (bi.is_brk || b == ilt_pkg::CH_NUL) begin
          fin = ilt_pkg::ST_BAD_TAG;
        end else begin
          e_cls = ilt_pkg::CLS_TAG_VAL; e_char = b;
          e_start = (phase == ilt_pkg::PH_VAL_FIRST);
        end
      end
      ilt_pkg::PH_PFX_FIRST: begin
        if (b == ilt_pkg::CH_SPACE) begin
          fin = ilt_pkg::ST_BAD_PFX;
        end else begin
          e_cls = ilt_pkg::CLS_PREFIX; e_char = b; e_start = 1'b1;
        end
      end
      ilt_pkg::PH_PFX: begin
        e_char = b;
        e_cls  = (b == ilt_pkg::CH_SPACE) ? ilt_pkg::CLS_DELIM : ilt_pkg::CLS_PREFIX;
      end
      ilt_pkg::PH_CMD_ALPHA, ilt_pkg::PH_CMD_NUM: begin
        if (phase == ilt_pkg::PH_CMD_ALPHA && bi.is_alpha) begin
          e_cls = ilt_pkg::CLS_CMD_LTR; e_char = b;
        end else if (phase == ilt_pkg::PH_CMD_NUM && digit_count < ilt_pkg::NUM_DIGITS) begin
          if (bi.is_digit) begin
            e_cls = ilt_pkg::CLS_CMD_DIG; e_char = b;
          end else begin
            fin = ilt_pkg::ST_BAD_CMD;
          end
        end else if (b == ilt_pkg::CH_SPACE) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b;
        end else if (bi.is_brk) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b; fin = ilt_pkg::ST_OK;
        end else begin
          fin = ilt_pkg::ST_NO_TERM;
        end
      end
      ilt_pkg::PH_PSPACE: begin
        if (b == ilt_pkg::CH_COLON) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b;
        end else if (param_count < ilt_pkg::MAX_PARAMS) begin
          if (b == ilt_pkg::CH_SPACE || bi.is_brk) begin
            fin = ilt_pkg::ST_BAD_PARAM;
          end else begin
            e_cls = ilt_pkg::CLS_MIDDLE; e_char = b; e_start = 1'b1;
          end
        end else if (bi.is_brk) begin
          e_cls = ilt_pkg::CLS_DELIM; e_char = b; fin = ilt_pkg::ST_OK;
        end else begin
          e_cls = ilt_pkg::CLS_TRAIL; e_char = b; e_start = 1'b1;
        end
      end
      ilt_pkg::PH_MIDDLE: begin
        e_char = b;
        if (b == ilt_pkg::CH_SPACE) begin
          e_cls = ilt_pkg::CLS_DELIM;
        end else if (bi.is_brk) begin
          e_cls = ilt_pkg::CLS_DELIM; fin = ilt_pkg::ST_OK;
        end else begin
          e_cls = ilt_pkg::CLS_MIDDLE;
        end
      end
      ilt_pkg::PH_TRAIL_FIRST, ilt_pkg::PH_TRAIL: begin
        e_char = b;
        if (bi.is_brk) begin
          e_cls = ilt_pkg::CLS_DELIM; fin = ilt_pkg::ST_OK;
        end else begin
          e_cls   = ilt_pkg::CLS_TRAIL;
          e_start = (phase == ilt_pkg::PH_TRAIL_FIRST);
        end
      end
      default: begin
        e_cls = ilt_pkg::CLS_NONE;
      end
    endcase
  end

  // Next state of the parser
  always_comb begin
    ph_u  = phase;
    vs_u  = vendor_seen;
    vr_u  = vendor_required;
    esc_u = escape_pending;
    pc_u  = param_count;
    dc_u  = digit_count;
    na_u  = number_accum;
    unique case (phase) inside
      ilt_pkg::PH_START, ilt_pkg::PH_AFTER_TAGS, ilt_pkg::PH_CMD_FIRST: begin
        if (phase == ilt_pkg::PH_START && b == ilt_pkg::CH_AT) begin
          ph_u = ilt_pkg::PH_KEY_FIRST; vs_u = 1'b0; vr_u = 1'b0;
        end else if (phase != ilt_pkg::PH_CMD_FIRST && b == ilt_pkg::CH_COLON) begin
          ph_u = ilt_pkg::PH_PFX_FIRST;
        end else if (bi.is_alpha) begin
          ph_u = ilt_pkg::PH_CMD_ALPHA;
        end else if (bi.is_digit) begin
          ph_u = ilt_pkg::PH_CMD_NUM;
          dc_u = 2'd1;
          na_u = {6'd0, b[3:0]};
        end
      end
      ilt_pkg::PH_KEY_FIRST, ilt_pkg::PH_KEY: begin
        if (bi.is_key_char) begin
          ph_u = ilt_pkg::PH_KEY;
        end else if ((b == ilt_pkg::CH_DOT || b == ilt_pkg::CH_COLON) && !vendor_seen) begin
          vr_u = 1'b1; ph_u = ilt_pkg::PH_KEY;
        end else if (b == ilt_pkg::CH_SLASH) begin
          if (!vendor_seen) begin
            vs_u = 1'b1; ph_u = ilt_pkg::PH_KEY;
          end
        end else if (!key_bad_vendor) begin
          if (b == ilt_pkg::CH_EQ) begin
            ph_u = ilt_pkg::PH_VAL_FIRST;
          end else if (b == ilt_pkg::CH_SEMI) begin
            ph_u = ilt_pkg::PH_KEY_FIRST; vs_u = 1'b0; vr_u = 1'b0;
          end else if (b == ilt_pkg::CH_SPACE) begin
            ph_u = ilt_pkg::PH_AFTER_TAGS;
          end
        end
      end
      ilt_pkg::PH_VAL_FIRST, ilt_pkg::PH_VAL: begin
        if (escape_pending) begin
          esc_u = 1'b0;
          if (esc_ok) begin
            ph_u = ilt_pkg::PH_VAL;
          end
        end else if (b == ilt_pkg::CH_BSLASH) begin
          esc_u = 1'b1;
        end else if (b == ilt_pkg::CH_SEMI) begin
          ph_u = ilt_pkg::PH_KEY_FIRST; vs_u = 1'b0; vr_u = 1'b0;
        end else if (b == ilt_pkg::CH_SPACE) begin
          ph_u = ilt_pkg::PH_AFTER_TAGS;
        end else if (!(bi.is_brk || b == ilt_pkg::CH_NUL)) begin
          ph_u = ilt_pkg::PH_VAL;
        end
      end
      ilt_pkg::PH_PFX_FIRST: begin
        if (b != ilt_pkg::CH_SPACE) begin
          ph_u = ilt_pkg::PH_PFX;
        end
      end
      ilt_pkg::PH_PFX: begin
        if (b == ilt_pkg::CH_SPACE) begin
          ph_u = ilt_pkg::PH_CMD_FIRST;
        end
      end
      ilt_pkg::PH_CMD_ALPHA, ilt_pkg::PH_CMD_NUM: begin
        if (phase == ilt_pkg::PH_CMD_ALPHA && bi.is_alpha) begin
          ph_u = phase;
        end else if (phase == ilt_pkg::PH_CMD_NUM && digit_count < ilt_pkg::NUM_DIGITS) begin
          if (bi.is_digit) begin
            na_u = na_times10 + {6'd0, b[3:0]};
            dc_u = digit_count + 2'd1;
          end
        end else if (b == ilt_pkg::CH_SPACE) begin
          pc_u = 4'd1; ph_u = ilt_pkg::PH_PSPACE;
        end
      end
      ilt_pkg::PH_PSPACE: begin
        if (b == ilt_pkg::CH_COLON) begin
          ph_u = ilt_pkg::PH_TRAIL_FIRST;
        end else if (param_count < ilt_pkg::MAX_PARAMS) begin
          if (!(b == ilt_pkg::CH_SPACE || bi.is_brk)) begin
            ph_u = ilt_pkg::PH_MIDDLE;
          end
        end else if (!bi.is_brk) begin
          ph_u = ilt_pkg::PH_TRAIL;
        end
      end
      ilt_pkg::PH_MIDDLE: begin
        if (b == ilt_pkg::CH_SPACE) begin
          ph_u = ilt_pkg::PH_PSPACE;
          if (param_count < ilt_pkg::MAX_PARAMS) begin
            pc_u = param_count + 4'd1;
          end
        end
      end
      ilt_pkg::PH_TRAIL_FIRST, ilt_pkg::PH_TRAIL: begin
        if (!bi.is_brk) begin
          ph_u = ilt_pkg::PH_TRAIL;
        end
      end
      default: begin
        ph_u = phase;
      end
    endcase

    // Finish the line on an error, a break or the buffer end
    done  = 1'b0;
    err_u = error_latch;
    if (fin != ilt_pkg::ST_PENDING) begin
      err_u = fin; done = 1'b1; ph_u = ilt_pkg::PH_DONE;
    end else if (phase != ilt_pkg::PH_DONE && bi.last) begin
      err_u = end_code(ph_u, dc_u, pc_u); done = 1'b1;
    end

    // The buffer end rearms the parser for a new line
    if (bi.last) begin
      phase_next           = ilt_pkg::PH_START;
      vendor_seen_next     = 1'b0;
      vendor_required_next = 1'b0;
      escape_pending_next  = 1'b0;
      param_count_next     = 4'd0;
      digit_count_next     = 2'd0;
      number_accum_next    = 10'd0;
      error_latch_next     = ilt_pkg::ST_PENDING;
    end else begin
      phase_next           = ph_u;
      vendor_seen_next     = vs_u;
      vendor_required_next = vr_u;
      escape_pending_next  = esc_u;
      param_count_next     = pc_u;
      digit_count_next     = dc_u;
      number_accum_next    = na_u;
      error_latch_next     = err_u;
    end
  end

  // Assemble the result record
  always_comb begin
    if (fin != ilt_pkg::ST_PENDING && fin != ilt_pkg::ST_OK) begin
      r.out_char    = 8'h00;
      r.token_class = ilt_pkg::CLS_NONE;
      r.token_start = 1'b0;
    end else begin
      r.out_char    = e_char;
      r.token_class = e_cls;
      r.token_start = e_start;
    end
    r.param_index = (r.token_class == ilt_pkg::CLS_MIDDLE ||
                     r.token_class == ilt_pkg::CLS_TRAIL) ? pc_u : 4'd0;
    r.command_is_numeric = (dc_u == ilt_pkg::NUM_DIGITS);
    r.command_number     = (dc_u == ilt_pkg::NUM_DIGITS) ? na_u : 10'd0;
    r.done_res           = done;
    r.status             = err_u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ilt_pkg::PH_START;
      vendor_seen     <= 1'b0;
      vendor_required <= 1'b0;
      escape_pending  <= 1'b0;
      param_count     <= 4'd0;
      digit_count     <= 2'd0;
      number_accum    <= 10'd0;
      error_latch     <= ilt_pkg::ST_PENDING;
    end else if (take) begin
      phase           <= phase_next;
      vendor_seen     <= vendor_seen_next;
      vendor_required <= vendor_required_next;
      escape_pending  <= escape_pending_next;
      param_count     <= param_count_next;
      digit_count     <= digit_count_next;
      number_accum    <= number_accum_next;
      error_latch     <= error_latch_next;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (take) begin
      oq[wr_ptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({take, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign empty = (count == 2'd0);
  assign res   = oq[rd_ptr];

endmodule

[rtl/irc_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer: streaming IRC message line tokenizer
// Classifies each byte of an IRC line (tags, prefix, command, parameters,
// delimiters), decodes tag value escapes and reports the line status.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer when      payload
//  --------  ---------  -----------------  -----------------------------------
//  input     in         push  && !full     in_byte, in_last
//  result    out        pop   && !empty    out_char, token_class, token_start,
//                                          param_index, command_is_numeric,
//                                          command_number, done_res, status
//
//  One byte per cycle sustained while results are popped; one result per
//  byte, in order; each result is registered in the result queue.
//  The parser advances only when the result queue has room, so a stalled
//  result side fills both two-entry queues and then raises full.
//  Synchronous reset empties both queues and returns the parser to the
//  start of a line; a byte with in_last also rearms the parser.
//
module irc_line_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [3:0] token_class,
  output logic       token_start,
  output logic [3:0] param_index,
  output logic       command_is_numeric,
  output logic [9:0] command_number,
  output logic       done_res,
  output logic [2:0] status
);

  ilt_pkg::front_out_t fout;
  ilt_pkg::result_t    res;
  logic                take;

  // Classify incoming bytes and hold them for the parser
  ilt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .fout    (fout),
    .take    (take)
  );

  // Parse one byte per cycle while the result queue has room; queue its result
  ilt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .fin_q (fout),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  assign out_char           = res.out_char;
  assign token_class        = res.token_class;
  assign token_start        = res.token_start;
  assign param_index        = res.param_index;
  assign command_is_numeric = res.command_is_numeric;
  assign command_number     = res.command_number;
  assign done_res           = res.done_res;
  assign status             = res.status;

endmodule

[dv/irc_token_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_token_checker: scoreboard for the IRC line tokenizer
// Watches both queue channels and predicts the token of every accepted byte
// from its own model of the line grammar. It compares each popped result
// field by field and counts the failures.
// ----------------------------------------------------------------------------
module irc_token_checker
  import ilt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic [3:0] token_class,
  input  logic       token_start,
  input  logic [3:0] param_index,
  input  logic       command_is_numeric,
  input  logic [9:0] command_number,
  input  logic       done_res,
  input  logic [2:0] status,
  output int         fail_count,
  output int         outstanding
);

  // Parser state of the model
  phase_t     ph;
  logic       vend_seen;
  logic       vend_req;
  logic       esc_pend;
  logic [3:0] pcount;
  logic [1:0] dcount;
  logic [9:0] num_acc;
  logic [2:0] err_lat;

  // Token under construction for the current byte
  logic [3:0] t_cls;
  logic [7:0] t_char;
  logic       t_start;
  logic [2:0] t_fin;

  result_t token_q[$];

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_brk(input logic [7:0] b);
    return b == CH_CR || b == CH_LF;
  endfunction

  function void emit(input logic [3:0] cls, input logic [7:0] b, input logic first);
    t_cls   = cls;
    t_char  = b;
    t_start = first;
  endfunction

  function void emit_delim(input logic [7:0] b);
    emit(CLS_DELIM, b, 1'b0);
  endfunction

  function void open_key();
    vend_seen = 1'b0;
    vend_req  = 1'b0;
    ph        = PH_KEY_FIRST;
  endfunction

  function void clear_line();
    ph        = PH_START;
    vend_seen = 1'b0;
    vend_req  = 1'b0;
    esc_pend  = 1'b0;
    pcount    = '0;
    dcount    = '0;
    num_acc   = '0;
    err_lat   = ST_PENDING;
  endfunction

  function void start_command(input logic [7:0] b);
    if (is_alpha(b)) begin
      emit(CLS_CMD_LTR, b, 1'b1);
      ph = PH_CMD_ALPHA;
    end else if (is_digit(b)) begin
      emit(CLS_CMD_DIG, b, 1'b1);
      dcount  = 2'd1;
      num_acc = 10'(b - CH_ZERO);
      ph      = PH_CMD_NUM;
    end else begin
      t_fin = ST_BAD_CMD;
    end
  endfunction

  function void end_command(input logic [7:0] b);
    if (b == CH_SPACE) begin
      emit_delim(b);
      pcount = 4'd1;
      ph     = PH_PSPACE;
    end else if (is_brk(b)) begin
      emit_delim(b);
      t_fin = ST_OK;
    end else begin
      t_fin = ST_NO_TERM;
    end
  endfunction

  function void close_key(input logic [7:0] b);
    if (vend_req && !vend_seen) begin
      t_fin = ST_BAD_TAG;
    end else if (b == CH_EQ) begin
      emit_delim(b);
      ph = PH_VAL_FIRST;
    end else if (b == CH_SEMI) begin
      emit_delim(b);
      open_key();
    end else if (b == CH_SPACE) begin
      emit_delim(b);
      ph = PH_AFTER_TAGS;
    end else begin
      t_fin = ST_BAD_TAG;
    end
  endfunction

  // Status when the buffer ends before the line does
  function automatic logic [2:0] truncation_status();
    case (ph)
      PH_KEY_FIRST, PH_KEY, PH_VAL_FIRST, PH_VAL: return ST_BAD_TAG;
      PH_PFX_FIRST, PH_PFX:                       return ST_BAD_PFX;
      PH_START, PH_AFTER_TAGS, PH_CMD_FIRST:      return ST_BAD_CMD;
      PH_CMD_NUM: return (dcount < NUM_DIGITS) ? ST_BAD_CMD : ST_NO_TERM;
      PH_PSPACE:  return (pcount < MAX_PARAMS) ? ST_BAD_PARAM : ST_NO_TERM;
      default:    return ST_NO_TERM;
    endcase
  endfunction

  function automatic result_t tokenize(input logic [7:0] b, input logic last);
    result_t    r;
    logic       first;
    logic       known;
    logic [7:0] dec;
    logic       done;

    t_cls   = CLS_NONE;
    t_char  = '0;
    t_start = 1'b0;
    t_fin   = ST_PENDING;
    done    = 1'b0;
    first   = (ph == PH_KEY_FIRST) || (ph == PH_VAL_FIRST) || (ph == PH_TRAIL_FIRST);

    case (ph)
      PH_START: begin
        if (b == CH_AT) begin
          emit_delim(b);
          open_key();
        end else if (b == CH_COLON) begin
          emit_delim(b);
          ph = PH_PFX_FIRST;
        end else begin
          start_command(b);
        end
      end
      PH_AFTER_TAGS: begin
        if (b == CH_COLON) begin
          emit_delim(b);
          ph = PH_PFX_FIRST;
        end else begin
          start_command(b);
        end
      end
      PH_KEY_FIRST, PH_KEY: begin
        if (is_alpha(b) || is_digit(b) || b == CH_DASH) begin
          emit(CLS_TAG_KEY, b, first);
          ph = PH_KEY;
        end else if (b == CH_DOT || b == CH_COLON) begin
          if (!vend_seen) begin
            vend_req = 1'b1;
            emit(CLS_TAG_KEY, b, first);
            ph = PH_KEY;
          end else begin
            close_key(b);
          end
        end else if (b == CH_SLASH) begin
          if (!vend_seen) begin
            vend_seen = 1'b1;
            emit(CLS_TAG_KEY, b, first);
            ph = PH_KEY;
          end else begin
            t_fin = ST_BAD_TAG;
          end
        end else begin
          close_key(b);
        end
      end
      PH_VAL_FIRST, PH_VAL: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          known    = 1'b1;
          dec      = '0;
          case (b)
            CH_COLON:  dec = CH_SEMI;
            CH_LO_S:   dec = CH_SPACE;
            CH_BSLASH: dec = CH_BSLASH;
            CH_LO_R:   dec = CH_CR;
            CH_LO_N:   dec = CH_LF;
            default:   known = 1'b0;
          endcase
          if (known) begin
            emit(CLS_TAG_VAL, dec, first);
            ph = PH_VAL;
          end else begin
            t_fin = ST_BAD_TAG;
          end
        end else if (b == CH_BSLASH) begin
          esc_pend = 1'b1;
        end else if (b == CH_SEMI) begin
          emit_delim(b);
          open_key();
        end else if (b == CH_SPACE) begin
          emit_delim(b);
          ph = PH_AFTER_TAGS;
        end else if (is_brk(b) || b == CH_NUL) begin
          t_fin = ST_BAD_TAG;
        end else begin
          emit(CLS_TAG_VAL, b, first);
          ph = PH_VAL;
        end
      end
      PH_PFX_FIRST: begin
        if (b == CH_SPACE) begin
          t_fin = ST_BAD_PFX;
        end else begin
          emit(CLS_PREFIX, b, 1'b1);
          ph = PH_PFX;
        end
      end
      PH_PFX: begin
        if (b == CH_SPACE) begin
          emit_delim(b);
          ph = PH_CMD_FIRST;
        end else begin
          emit(CLS_PREFIX, b, 1'b0);
        end
      end
      PH_CMD_FIRST: start_command(b);
      PH_CMD_ALPHA: begin
        if (is_alpha(b)) emit(CLS_CMD_LTR, b, 1'b0);
        else end_command(b);
      end
      PH_CMD_NUM: begin
        if (dcount < NUM_DIGITS) begin
          if (is_digit(b)) begin
            emit(CLS_CMD_DIG, b, 1'b0);
            num_acc = num_acc * 10'd10 + 10'(b - CH_ZERO);
            dcount  = dcount + 2'd1;
          end else begin
            t_fin = ST_BAD_CMD;
          end
        end else begin
          end_command(b);
        end
      end
      PH_PSPACE: begin
        if (b == CH_COLON) begin
          emit_delim(b);
          ph = PH_TRAIL_FIRST;
        end else if (pcount < MAX_PARAMS) begin
          if (b == CH_SPACE || is_brk(b)) begin
            t_fin = ST_BAD_PARAM;
          end else begin
            emit(CLS_MIDDLE, b, 1'b1);
            ph = PH_MIDDLE;
          end
        end else if (is_brk(b)) begin
          emit_delim(b);
          t_fin = ST_OK;
        end else begin
          emit(CLS_TRAIL, b, 1'b1);
          ph = PH_TRAIL;
        end
      end
      PH_MIDDLE: begin
        if (b == CH_SPACE) begin
          emit_delim(b);
          if (pcount < MAX_PARAMS) pcount = pcount + 4'd1;
          ph = PH_PSPACE;
        end else if (is_brk(b)) begin
          emit_delim(b);
          t_fin = ST_OK;
        end else begin
          emit(CLS_MIDDLE, b, 1'b0);
        end
      end
      PH_TRAIL_FIRST, PH_TRAIL: begin
        if (is_brk(b)) begin
          emit_delim(b);
          t_fin = ST_OK;
        end else begin
          emit(CLS_TRAIL, b, first);
          ph = PH_TRAIL;
        end
      end
      default: ;
    endcase

    // Latch the first end of the line; an error drops the token
    if (ph != PH_DONE || t_fin != ST_PENDING) begin
      if (t_fin != ST_PENDING) begin
        if (t_fin != ST_OK) begin
          t_cls   = CLS_NONE;
          t_char  = '0;
          t_start = 1'b0;
        end
        err_lat = t_fin;
        done    = 1'b1;
        ph      = PH_DONE;
      end else if (last) begin
        err_lat = truncation_status();
        done    = 1'b1;
      end
    end

    r.out_char           = t_char;
    r.token_class        = t_cls;
    r.token_start        = t_start;
    r.param_index        = (t_cls == CLS_MIDDLE || t_cls == CLS_TRAIL) ? pcount : 4'd0;
    r.command_is_numeric = (dcount == NUM_DIGITS);
    r.command_number     = (dcount == NUM_DIGITS) ? num_acc : 10'd0;
    r.done_res           = done;
    r.status             = err_lat;

    if (last) clear_line();
    return r;
  endfunction

  function void check_field(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_line();
      token_q.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          fail_count++;
          $error("result transfer with no token pending");
        end else begin
          want = token_q.pop_front();
          check_field("out_char", want.out_char, out_char);
          check_field("token_class", want.token_class, token_class);
          check_field("token_start", want.token_start, token_start);
          check_field("param_index", want.param_index, param_index);
          check_field("command_is_numeric", want.command_is_numeric, command_is_numeric);
          check_field("command_number", want.command_number, command_number);
          check_field("done_res", want.done_res, done_res);
          check_field("status", want.status, status);
        end
      end
      if (push && !full) token_q.insert(token_q.size(), tokenize(in_byte, in_last));
      outstanding = token_q.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the IRC line tokenizer
// Streams directed and random IRC lines (tags, prefix, command, parameters,
// broken and truncated lines, noise) into the block under three idle
// patterns and a long result-side hold-off; a scoreboard checks every token.
// ----------------------------------------------------------------------------
module testbench;
  import ilt_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RANDOM_BYTES  = 1600;
  localparam int HOLD_CYCLES   = 48;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TIME_LIMIT_NS = 2_000_000;

  typedef enum int {TXT_VALUE, TXT_PREFIX, TXT_MIDDLE, TXT_TRAIL} text_kind_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic [3:0] token_class;
  logic       token_start;
  logic [3:0] param_index;
  logic       command_is_numeric;
  logic [9:0] command_number;
  logic       done_res;
  logic [2:0] status;

  int fail_count;
  int outstanding;

  // Idle odds in percent per cycle for each side
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int bytes_sent  = 0;

  // Bytes of the buffer being built; the last one carries in_last
  logic [7:0] line_buf[$];

  logic [7:0] esc_codes[5]      = '{CH_COLON, CH_LO_S, CH_BSLASH, CH_LO_R, CH_LO_N};
  logic [7:0] grammar_bytes[11] = '{CH_AT, CH_COLON, CH_SEMI, CH_EQ, CH_SLASH, CH_DOT,
                                    CH_SPACE, CH_BSLASH, CH_CR, CH_LF, CH_NUL};

  irc_line_tokenizer u_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .in_last            (in_last),
    .empty              (empty),
    .pop                (pop),
    .out_char           (out_char),
    .token_class        (token_class),
    .token_start        (token_start),
    .param_index        (param_index),
    .command_is_numeric (command_is_numeric),
    .command_number     (command_number),
    .done_res           (done_res),
    .status             (status)
  );

  irc_token_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .in_last            (in_last),
    .empty              (empty),
    .pop                (pop),
    .out_char           (out_char),
    .token_class        (token_class),
    .token_start        (token_start),
    .param_index        (param_index),
    .command_is_numeric (command_is_numeric),
    .command_number     (command_number),
    .done_res           (done_res),
    .status             (status),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #(TIME_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: pop at random odds; on request, hold pop low for a long
  // stretch so that both internal queues fill and full rises.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          pop <= 1'b0;
          @(negedge clk);
        end
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one byte from a falling edge; return at the falling edge after
  // the transfer. full is read just after the rising edge, so it still
  // holds the value that decided the transfer.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Send the whole buffer, marking its final byte as the end of input
  task automatic send_buffer();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Append one byte to the buffer being built
  function automatic void add_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_buffer();
  endtask

  function automatic logic [7:0] pick_key_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return CH_LO_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    if (r < 62) return CH_ZERO + 8'(r - 52);
    return CH_DASH;
  endfunction

  // Mostly printable, sometimes any byte; drop what the field may not hold
  function automatic logic [7:0] pick_char(input text_kind_t kind);
    logic [7:0] b;
    bit         bad;
    do begin
      if ($urandom_range(4) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(8'h7E, 8'h21));
      case (kind)
        TXT_VALUE:  bad = b == CH_SPACE || b == CH_SEMI || b == CH_BSLASH ||
                          b == CH_CR || b == CH_LF || b == CH_NUL;
        TXT_PREFIX: bad = b == CH_SPACE;
        TXT_MIDDLE: bad = b == CH_SPACE || b == CH_CR || b == CH_LF;
        default:    bad = b == CH_CR || b == CH_LF;
      endcase
    end while (bad);
    return b;
  endfunction

  // Build one buffer: mostly a well-formed line with random content, the
  // rest a line with one byte broken, a line cut short, or plain noise.
  task automatic build_line();
    int         kind;
    int         nkeys;
    int         nparams;
    int         pos;
    logic [7:0] b;

    kind = $urandom_range(99);
    if (kind >= 93) begin
      repeat ($urandom_range(10, 1)) add_byte(8'($urandom_range(255)));
      return;
    end

    // Tag section, with vendor keys, empty keys and escaped values
    if ($urandom_range(1)) begin
      add_byte(CH_AT);
      nkeys = $urandom_range(3, 1);
      for (int k = 0; k < nkeys; k++) begin
        if (k > 0) add_byte(CH_SEMI);
        if ($urandom_range(4) != 0) begin
          if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(3, 1)) add_byte(pick_key_char());
            add_byte(CH_DOT);
            repeat ($urandom_range(3, 1)) add_byte(pick_key_char());
            add_byte(CH_SLASH);
          end
          repeat ($urandom_range(5, 1)) add_byte(pick_key_char());
        end
        if ($urandom_range(4) < 3) begin
          add_byte(CH_EQ);
          repeat ($urandom_range(5)) begin
            if ($urandom_range(3) == 0) begin
              add_byte(CH_BSLASH);
              add_byte(esc_codes[$urandom_range(4)]);
            end else begin
              add_byte(pick_char(TXT_VALUE));
            end
          end
        end
      end
      add_byte(CH_SPACE);
    end

    // Prefix; it may hold CR or LF, since only a space ends it
    if ($urandom_range(4) < 2) begin
      add_byte(CH_COLON);
      repeat ($urandom_range(8, 1)) add_byte(pick_char(TXT_PREFIX));
      add_byte(CH_SPACE);
    end

    // Command: letters or exactly three digits
    if ($urandom_range(1)) begin
      repeat ($urandom_range(6, 1))
        add_byte(($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'($urandom_range(25)));
    end else begin
      repeat (3) add_byte(CH_ZERO + 8'($urandom_range(9)));
    end

    // Parameters: usually a few, sometimes up to the fifteenth
    nparams = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(16, 12);
    if (nparams > 15) nparams = 15;
    for (int i = 1; i <= nparams; i++) begin
      add_byte(CH_SPACE);
      if (i == nparams && $urandom_range(1)) begin
        add_byte(CH_COLON);
        repeat ($urandom_range(8)) add_byte(pick_char(TXT_TRAIL));
      end else if (i == 15) begin
        repeat ($urandom_range(8, 1)) add_byte(pick_char(TXT_TRAIL));
      end else begin
        do b = pick_char(TXT_MIDDLE); while (b == CH_COLON);
        add_byte(b);
        repeat ($urandom_range(6)) add_byte(pick_char(TXT_MIDDLE));
      end
    end

    // Terminator: CR, LF or CR LF; now and then junk after the line end
    case ($urandom_range(2))
      0: add_byte(CH_CR);
      1: add_byte(CH_LF);
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    endcase
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));

    if (kind >= 85) begin
      // Cut the line short so the buffer ends inside it
      pos = $urandom_range(line_buf.size() - 1, 1);
      while (line_buf.size() > pos) void'(line_buf.pop_back());
    end else if (kind >= 70) begin
      // Break one byte, often with a character that the grammar uses
      pos = $urandom_range(line_buf.size() - 1);
      if ($urandom_range(1)) line_buf[pos] = grammar_bytes[$urandom_range(10)];
      else line_buf[pos] = 8'($urandom_range(255));
    end
  endtask

  task automatic run_random(input int budget);
    int first_count;
    first_count = bytes_sent;
    while (bytes_sent - first_count < budget) begin
      build_line();
      send_buffer();
    end
  endtask

  initial begin
    push    = 1'b0;
    in_byte = '0;
    in_last = 1'b0;
    rst     = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Slow sender, slower receiver
    tx_idle_pct = 37;
    rx_idle_pct = 83;

    // Vendor key, escapes in the first value byte, prefix, numeric command,
    // middle and trailing parameters, CR end; then a lone 0xFF as the last
    // byte of a buffer, which is a bad command.
    send_text("@v.x/k=\\:\\n :p 123 m :t\015");
    send_text("\377");
    run_random(RANDOM_BYTES / 3);

    // Roles swapped: the sender idles most of the time
    tx_idle_pct = 83;
    rx_idle_pct = 37;
    run_random(RANDOM_BYTES / 3);

    // Full rate, opened by a long result-side hold-off so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random(RANDOM_BYTES / 3);
    push <= 1'b0;

    // Drain every pending token, then allow the pipeline latency to settle
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ilt_pkg.sv
rtl/ilt_front.sv
rtl/ilt_back.sv
rtl/irc_line_tokenizer.sv
dv/irc_token_checker.sv
dv/testbench.sv
